FILE: hw/rtl/mlpt_pkg.sv
`timescale 1ns / 1ps
package mlpt_pkg;

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;
    localparam int PX_W    = 12;
    localparam int VAL_W   = 64;
    localparam int DK_W    = SLOPE_W + 1;
    localparam int DC_W    = ICPT_W + 1;
    localparam int QDEPTH  = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
        logic signed [PX_W-1:0]    point_x;
    } t_req;

    typedef struct packed {
        logic                      valid;
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  intercept;
    } t_node;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_bk_stat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_DIF,
        S_ML,
        S_MM,
        S_CMP
    } t_state;

endpackage

FILE: hw/rtl/mlpt_front.sv
`timescale 1ns / 1ps
module mlpt_front import mlpt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic signed [SLOPE_W-1:0] i_slope,
    input  logic signed [ICPT_W-1:0]  i_intercept,
    input  logic signed [PX_W-1:0]    i_point_x,
    input  t_bk_stat                  i_stat,
    output t_req                      o_req,
    output logic                      o_req_vld
);

    t_req       r_q [QDEPTH];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wr, r_rd;
    logic       w_push, w_pop;
    t_req       w_in;

    assign busy      = (r_cnt == 2'(QDEPTH)) || i_stat.clearing;
    assign w_push    = start && !busy;
    assign w_pop     = i_stat.pop && (r_cnt != 2'd0);
    assign o_req_vld = (r_cnt != 2'd0);
    assign o_req     = r_q[r_rd];

    always_comb begin
        w_in.req_type  = i_req_type;
        w_in.slope     = (i_req_type == REQ_INSERT) ? i_slope : '0;
        w_in.intercept = (i_req_type == REQ_INSERT) ? i_intercept : '0;
        w_in.point_x   = (i_req_type == REQ_QUERY) ? i_point_x : '0;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

endmodule

FILE: hw/rtl/mlpt_back.sv
`timescale 1ns / 1ps
module mlpt_back import mlpt_pkg::*; #(
    parameter int X_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_req                    i_req,
    input  logic                    i_req_vld,
    output t_bk_stat                o_stat,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_min_value,
    output logic                    o_tree_empty
);

    localparam int AW    = X_BITS + 1;
    localparam int NODES = 1 << AW;
    localparam int CW    = ((X_BITS > PX_W) ? X_BITS : PX_W) + 1;
    localparam int PW    = DK_W + CW;

    t_state r_state, n_state;
    t_node  r_mem [NODES];
    t_node  r_rdq;

    logic [AW-1:0]              r_clr, n_clr;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_type, n_type;
    logic signed [SLOPE_W-1:0]  r_k, n_k, r_ok, n_ok;
    logic signed [ICPT_W-1:0]   r_c, n_c, r_oc, n_oc;
    logic signed [PX_W-1:0]     r_x, n_x;
    logic signed [X_BITS-1:0]   r_l, n_l, r_r, n_r;
    logic signed [DK_W-1:0]     r_dk, n_dk;
    logic signed [DC_W-1:0]     r_dc, n_dc;
    logic signed [PW-1:0]       r_pl, n_pl, r_pm, n_pm;
    logic signed [VAL_W-1:0]    r_best, n_best;
    logic                       r_ov, n_ov, r_oe, n_oe;
    logic signed [VAL_W-1:0]    r_omin, n_omin;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    t_node                      w_wdata;
    logic                       w_pop;

    logic [X_BITS:0]            w_span;
    logic signed [X_BITS-1:0]   w_m;
    logic signed [CW-1:0]       w_me, w_xe, w_le, w_b;
    logic signed [PW-1:0]       w_prod;
    logic signed [VAL_W-1:0]    w_v, w_bnew;
    logic                       w_lo_l, w_lo_m, w_leaf, w_dir;

    assign w_span = {r_r[X_BITS-1], r_r} - {r_l[X_BITS-1], r_l};
    assign w_m    = r_l + X_BITS'(w_span >> 1);
    assign w_me   = CW'(w_m);
    assign w_le   = CW'(r_l);
    assign w_xe   = CW'(r_x);
    assign w_b    = (r_state == S_MM) ? w_me : ((r_type == REQ_QUERY) ? w_xe : w_le);
    assign w_prod = PW'(r_dk) * PW'(w_b);
    assign w_v    = VAL_W'(r_pl) + VAL_W'(r_oc);
    assign w_bnew = ((r_addr == AW'(1)) || (w_v < r_best)) ? w_v : r_best;
    assign w_lo_l = VAL_W'(r_pl) < VAL_W'(r_dc);
    assign w_lo_m = VAL_W'(r_pm) < VAL_W'(r_dc);
    assign w_leaf = (r_l == r_r);
    assign w_dir  = (r_type == REQ_QUERY) ? (w_xe > w_me) : (w_lo_l == w_lo_m);

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.pop      = w_pop;
    assign o_valid         = r_ov;
    assign o_min_value     = r_omin;
    assign o_tree_empty    = r_oe;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (i_req_vld) n_state = S_RD;
            S_RD:    n_state = S_DIF;
            S_DIF:   n_state = r_rdq.valid ? S_ML : S_IDLE;
            S_ML:    n_state = (r_type == REQ_QUERY) ? S_CMP : S_MM;
            S_MM:    n_state = S_CMP;
            S_CMP:   n_state = w_leaf ? S_IDLE : S_RD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr;   n_addr = r_addr; n_type = r_type;
        n_k = r_k;       n_c = r_c;       n_x = r_x;
        n_ok = r_ok;     n_oc = r_oc;     n_l = r_l;     n_r = r_r;
        n_dk = r_dk;     n_dc = r_dc;     n_pl = r_pl;   n_pm = r_pm;
        n_best = r_best; n_ov = 1'b0;     n_oe = r_oe;   n_omin = r_omin;
        w_we = 1'b0;     w_waddr = r_addr; w_wdata = '0;  w_pop = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
            end
            S_IDLE: begin
                w_pop  = i_req_vld;
                n_type = i_req.req_type;
                n_k    = i_req.slope;
                n_c    = i_req.intercept;
                n_x    = i_req.point_x;
                n_addr = AW'(1);
                n_l    = {1'b1, {(X_BITS-1){1'b0}}};
                n_r    = {1'b0, {(X_BITS-1){1'b1}}};
            end
            S_DIF: begin
                n_ok = r_rdq.slope;
                n_oc = r_rdq.intercept;
                n_dk = (r_type == REQ_QUERY) ? DK_W'(r_rdq.slope)
                                             : DK_W'(r_k) - DK_W'(r_rdq.slope);
                n_dc = DC_W'(r_rdq.intercept) - DC_W'(r_c);
                if (!r_rdq.valid) begin
                    if (r_type == REQ_INSERT) begin
                        w_we    = 1'b1;
                        w_wdata = '{valid: 1'b1, slope: r_k, intercept: r_c};
                    end else begin
                        n_ov   = 1'b1;
                        n_oe   = (r_addr == AW'(1));
                        n_omin = (r_addr == AW'(1)) ? '0 : r_best;
                    end
                end
            end
            S_ML: n_pl = w_prod;
            S_MM: n_pm = w_prod;
            S_CMP: begin
                if (r_type == REQ_INSERT) begin
                    if (w_lo_m) begin
                        w_we    = 1'b1;
                        w_wdata = '{valid: 1'b1, slope: r_k, intercept: r_c};
                        n_k     = r_ok;
                        n_c     = r_oc;
                    end
                end else begin
                    n_best = w_bnew;
                    if (w_leaf) begin
                        n_ov   = 1'b1;
                        n_oe   = 1'b0;
                        n_omin = w_bnew;
                    end
                end
                n_addr = {r_addr[AW-2:0], w_dir};
                if (w_dir) begin
                    n_l = w_m + X_BITS'(1);
                end else begin
                    n_r = w_m;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdq <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr; r_type <= n_type; r_k <= n_k;   r_c <= n_c;
        r_x <= n_x;       r_ok <= n_ok;     r_oc <= n_oc; r_l <= n_l;
        r_r <= n_r;       r_dk <= n_dk;     r_dc <= n_dc; r_pl <= n_pl;
        r_pm <= n_pm;     r_best <= n_best; r_oe <= n_oe; r_omin <= n_omin;
    end

endmodule

FILE: hw/rtl/min_line_point_tree_top.sv
// Channel   Handshake          Fields
// request   start / busy       i_req_type, i_slope, i_intercept, i_point_x
// result    o_valid (1 cycle)  o_min_value, o_tree_empty
//
// At each tree level an insert steps through RD, DIF, ML, MM, CMP and a query
// skips MM, over at most X_BITS+1 levels, due to the one shared multiplier and the
// registered node memory read. Clearing all nodes after reset holds busy high.
// A two-entry queue takes requests while the walker works; busy rises when it is full.
// The receiver cannot stall: each result strobes for exactly one cycle.
`timescale 1ns / 1ps
module min_line_point_tree_top import mlpt_pkg::*; #(
    parameter int X_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic signed [SLOPE_W-1:0] i_slope,
    input  logic signed [ICPT_W-1:0]  i_intercept,
    input  logic signed [PX_W-1:0]    i_point_x,
    output logic                      o_valid,
    output logic signed [VAL_W-1:0]   o_min_value,
    output logic                      o_tree_empty
);

    t_req     w_req;
    logic     w_req_vld;
    t_bk_stat w_stat;

    mlpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_slope     (i_slope),
        .i_intercept (i_intercept),
        .i_point_x   (i_point_x),
        .i_stat      (w_stat),
        .o_req       (w_req),
        .o_req_vld   (w_req_vld)
    );

    mlpt_back #(.X_BITS(X_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_req_vld    (w_req_vld),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_min_value  (o_min_value),
        .o_tree_empty (o_tree_empty)
    );

endmodule

FILE: hw/rtl/mlpt_checker.sv
`timescale 1ns / 1ps
module mlpt_checker import mlpt_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    busy,
    input logic                    o_valid,
    input logic signed [VAL_W-1:0] o_min_value,
    input logic                    o_tree_empty
);

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tree_empty) |-> (o_min_value == '0))
        else $error("empty result carries a nonzero value");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results in adjacent cycles");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

endmodule

bind min_line_point_tree_top mlpt_checker u_mlpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_min_value  (o_min_value),
    .o_tree_empty (o_tree_empty)
);

FILE: bench/min_line_point_tree_top_test.sv
`timescale 1ns / 1ps
module min_line_point_tree_top_test;
    import mlpt_pkg::*;

    localparam int XB = 12;
    localparam int SLOTS = 1 << (XB + 1);

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_req_type;
    logic signed [SLOPE_W-1:0] i_slope;
    logic signed [ICPT_W-1:0]  i_intercept;
    logic signed [PX_W-1:0]    i_point_x;
    logic                      o_valid;
    logic signed [VAL_W-1:0]   o_min_value;
    logic                      o_tree_empty;

    min_line_point_tree_top #(.X_BITS(XB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_slope(i_slope), .i_intercept(i_intercept),
        .i_point_x(i_point_x), .o_valid(o_valid), .o_min_value(o_min_value),
        .o_tree_empty(o_tree_empty)
    );

    typedef struct {
        logic               chk;
        logic signed [63:0] val;
        logic               empty;
    } t_min_exp;

    typedef struct {
        logic               kind;
        logic signed [31:0] k;
        logic signed [47:0] c;
        logic signed [11:0] x;
        logic               fixed;
        logic signed [63:0] val;
        logic               empty;
    } t_row;

    bit                 lc_valid [SLOTS];
    logic signed [31:0] lc_slope [SLOTS];
    logic signed [47:0] lc_icpt  [SLOTS];
    t_min_exp           pending_min[$];
    int                 err_cnt;
    int                 send_idle_pct;
    bit                 queries_only;

    function automatic logic signed [63:0] eval_line(logic signed [31:0] k,
            logic signed [47:0] c, longint x);
        longint kk;
        longint cc;
        kk = k;
        cc = c;
        return kk * x + cc;
    endfunction

    task automatic tree_insert(logic signed [31:0] k0, logic signed [47:0] c0);
        int unsigned        t;
        int unsigned        ch;
        longint             l;
        longint             r;
        longint             m;
        bit                 lo_l;
        bit                 lo_m;
        logic signed [31:0] k;
        logic signed [47:0] c;
        logic signed [31:0] tk;
        logic signed [47:0] tc;
        t = 1;
        k = k0;
        c = c0;
        l = -(longint'(1) << (XB - 1));
        r = (longint'(1) << (XB - 1)) - 1;
        if (!lc_valid[1]) begin
            lc_valid[1] = 1;
            lc_slope[1] = k;
            lc_icpt[1] = c;
            return;
        end
        forever begin
            m = l + ((r - l) >>> 1);
            lo_l = eval_line(k, c, l) < eval_line(lc_slope[t], lc_icpt[t], l);
            lo_m = eval_line(k, c, m) < eval_line(lc_slope[t], lc_icpt[t], m);
            if (lo_m) begin
                tk = lc_slope[t];
                tc = lc_icpt[t];
                lc_slope[t] = k;
                lc_icpt[t] = c;
                k = tk;
                c = tc;
            end
            if (l >= r) return;
            if (lo_l != lo_m) begin
                ch = 2 * t;
                r = m;
            end else begin
                ch = 2 * t + 1;
                l = m + 1;
            end
            if (ch >= SLOTS) return;
            if (!lc_valid[ch]) begin
                lc_valid[ch] = 1;
                lc_slope[ch] = k;
                lc_icpt[ch] = c;
                return;
            end
            t = ch;
        end
    endtask

    function automatic t_min_exp tree_query(logic signed [11:0] px);
        t_min_exp           e;
        int unsigned        t;
        int unsigned        ch;
        longint             l;
        longint             r;
        longint             m;
        longint             x;
        logic signed [63:0] v;
        e.chk = 1;
        e.val = 0;
        e.empty = 1;
        if (!lc_valid[1]) return e;
        e.empty = 0;
        x = px;
        t = 1;
        l = -(longint'(1) << (XB - 1));
        r = (longint'(1) << (XB - 1)) - 1;
        e.val = eval_line(lc_slope[1], lc_icpt[1], x);
        forever begin
            m = l + ((r - l) >>> 1);
            v = eval_line(lc_slope[t], lc_icpt[t], x);
            if (v < e.val) e.val = v;
            if (l >= r) break;
            if (x <= m) begin
                ch = 2 * t;
                r = m;
            end else begin
                ch = 2 * t + 1;
                l = m + 1;
            end
            if (ch >= SLOTS || !lc_valid[ch]) break;
            t = ch;
        end
        return e;
    endfunction

    task automatic send_req(t_row rw);
        t_min_exp e;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        start = 1'b1;
        i_req_type = rw.kind;
        i_slope = rw.k;
        i_intercept = rw.c;
        i_point_x = rw.x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (rw.kind == REQ_INSERT) begin
            tree_insert(rw.k, rw.c);
        end else begin
            e = tree_query(rw.x);
            if (rw.fixed) begin
                if (e.val !== rw.val || e.empty !== rw.empty)
                    $display("%0t: table row disagrees with prediction", $time);
                e.val = rw.val;
                e.empty = rw.empty;
            end
            pending_min.push_back(e);
        end
        @(negedge i_clk);
        start = 1'b0;
        i_req_type = 1'($urandom_range(1));
        i_slope = $urandom;
        i_intercept = 48'({$urandom, $urandom});
        i_point_x = 12'($urandom);
    endtask

    function automatic t_row mk(logic kind, logic signed [31:0] k, logic signed [47:0] c,
            logic signed [11:0] x, logic fixed, logic signed [63:0] val, logic empty);
        t_row rw;
        rw.kind = kind;
        rw.k = k;
        rw.c = c;
        rw.x = x;
        rw.fixed = fixed;
        rw.val = val;
        rw.empty = empty;
        return rw;
    endfunction

    function automatic t_row rand_row();
        t_row rw;
        int   s;
        rw = mk(REQ_INSERT, $urandom, 48'({$urandom, $urandom}), 12'($urandom), 0, 0, 0);
        rw.kind = queries_only ? REQ_QUERY : ($urandom_range(99) < 55);
        s = $urandom_range(3);
        if (s == 0) begin
            rw.k = $signed($urandom_range(200)) - 100;
            rw.c = $signed(48'($urandom_range(200000))) - 48'sd100000;
        end else if (s == 1) begin
            rw.k = $signed($urandom_range(20000)) - 10000;
        end
        if ($urandom_range(9) == 0) rw.x = $urandom_range(1) ? 12'sh800 : 12'sh7ff;
        return rw;
    endfunction

    always @(posedge i_clk) begin
        t_min_exp e;
        if (i_rst_n && o_valid) begin
            if (pending_min.size() == 0) begin
                $display("%0t: unexpected result value=%0d empty=%0b",
                    $time, o_min_value, o_tree_empty);
                err_cnt++;
            end else begin
                e = pending_min.pop_front();
                if (o_min_value !== e.val) begin
                    $display("%0t: min_value expected %0d actual %0d",
                        $time, e.val, o_min_value);
                    err_cnt++;
                end
                if (o_tree_empty !== e.empty) begin
                    $display("%0t: tree_empty expected %0b actual %0b",
                        $time, e.empty, o_tree_empty);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

    t_row dir_tab[$];

    initial begin
        int wait_n;
        err_cnt = 0;
        send_idle_pct = 6;
        queries_only = 0;
        i_rst_n = 0;
        start = 0;
        i_req_type = 0;
        i_slope = 0;
        i_intercept = 0;
        i_point_x = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh800, 1, 0, 1));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh7ff, 1, 0, 1));
        dir_tab.push_back(mk(REQ_INSERT, 2, 5, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 0, 1, 5, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh7ff, 1, 4099, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh800, 1, -4091, 0));
        dir_tab.push_back(mk(REQ_INSERT, 2, 5, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, -2, 5, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 32'sh7fffffff, 48'sh7fffffffffff, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 32'sh80000000, 48'sh800000000000, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh7ff, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh800, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 32'sh80000000, 48'sh7fffffffffff, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 32'sh7fffffff, 48'sh800000000000, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 0, -48'sd7, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_INSERT, -1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, -1, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'sh555, 0, 0, 0));
        dir_tab.push_back(mk(REQ_QUERY, 0, 0, 12'shaaa, 0, 0, 0));
        foreach (dir_tab[i]) send_req(dir_tab[i]);

        for (int i = 0; i < 600; i++) begin
            if (i == 200) send_idle_pct = 73;
            if (i == 400) send_idle_pct = 0;
            if (i == 300) begin
                wait_n = 0;
                while (pending_min.size() != 0 && wait_n < 10000) begin
                    @(negedge i_clk);
                    wait_n++;
                end
            end
            if (i == 560) queries_only = 1;
            send_req(rand_row());
        end

        wait_n = 0;
        while (pending_min.size() != 0 && wait_n < 100000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0 && pending_min.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
